// ----- hdl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants for the cubic spline point evaluator
// Fixed-point widths, payload structs, opcodes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

    // Field widths
    localparam int CSP_COORD_WIDTH   = 32;
    localparam int CSP_U_FRAC_BITS   = 16;
    localparam int CSP_U_WIDTH       = CSP_U_FRAC_BITS + 1;
    localparam int CSP_TENSION_WIDTH = 9;

    // Internal datapath widths
    localparam int CSP_UU_WIDTH   = 2 * CSP_U_WIDTH;
    localparam int CSP_AB_WIDTH   = CSP_U_FRAC_BITS + 3;
    localparam int CSP_W_WIDTH    = CSP_U_FRAC_BITS + 13;
    localparam int CSP_LO_WIDTH   = CSP_COORD_WIDTH / 2;
    localparam int CSP_HI_WIDTH   = CSP_COORD_WIDTH - CSP_LO_WIDTH;
    localparam int CSP_LOP_WIDTH  = CSP_LO_WIDTH + 1 + CSP_W_WIDTH;
    localparam int CSP_HIP_WIDTH  = CSP_HI_WIDTH + CSP_W_WIDTH;
    localparam int CSP_PROD_WIDTH = CSP_COORD_WIDTH + CSP_W_WIDTH;
    localparam int CSP_ACC_WIDTH  = CSP_PROD_WIDTH + 3;
    localparam int CSP_SHIFT      = CSP_U_FRAC_BITS + 8;
    localparam int CSP_Q_WIDTH    = CSP_ACC_WIDTH - CSP_SHIFT;

    localparam int CSP_STAGES = 13;

    // Configuration port
    localparam int CSP_PADDR_WIDTH = 3;
    localparam int CSP_PDATA_WIDTH = 32;

    localparam logic [CSP_U_WIDTH-1:0] CSP_U_ONE  = CSP_U_WIDTH'(1) << CSP_U_FRAC_BITS;
    localparam logic [CSP_UU_WIDTH-1:0] CSP_U_HALF =
        CSP_UU_WIDTH'(1) << (CSP_U_FRAC_BITS - 1);
    localparam logic signed [CSP_ACC_WIDTH-1:0] CSP_ROUND =
        CSP_ACC_WIDTH'(1) << (CSP_SHIFT - 1);
    localparam logic [CSP_TENSION_WIDTH-1:0] CSP_TENSION_RESET = CSP_TENSION_WIDTH'(128);

    // Register indexes (word address bit of paddr)
    localparam logic CSP_REG_TENSION = 1'b0;

    typedef logic signed [CSP_COORD_WIDTH-1:0] csp_coord_t;

    typedef enum logic {
        CSP_OP_CATMULL_ROM = 1'b0,
        CSP_OP_BEZIER      = 1'b1
    } csp_op_t;

    typedef struct packed {
        csp_op_t                  opcode;
        csp_coord_t               ctrl_a;
        csp_coord_t               ctrl_b;
        csp_coord_t               ctrl_c;
        csp_coord_t               ctrl_d;
        logic [CSP_U_WIDTH-1:0]   param_u;
    } csp_sample_t;

    typedef struct packed {
        csp_coord_t curve_value;
        logic       saturated;
    } csp_result_t;

endpackage

`default_nettype wire

// ----- hdl/cubic_spline_point_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_spline_point_evaluator_unit: Catmull-Rom / Bezier coordinate evaluator
// Pipeline: 13 stages, from stage 0 (clamp) through stage 12 (result register).
// Throughput: one sample per cycle while results are taken; every stage holds one sample and no stage
// is more than one multiply deep, and bubbles collapse under a stalled output.
// Reset: clears all stage valid bits and sets tension to 128 (0.5).
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_spline_point_evaluator_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [csp_pkg::CSP_PADDR_WIDTH-1:0] paddr,
    input  wire logic [csp_pkg::CSP_PDATA_WIDTH-1:0] pwdata,
    output logic      [csp_pkg::CSP_PDATA_WIDTH-1:0] prdata,
    output logic                                     pready,
    // sample channel
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire csp_pkg::csp_sample_t                sample,
    // result channel
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output csp_pkg::csp_result_t                     result
);

    import csp_pkg::*;

    localparam int NS = CSP_STAGES;
    localparam int CW = CSP_COORD_WIDTH;
    localparam int F  = CSP_U_FRAC_BITS;
    localparam int UW = CSP_U_WIDTH;
    localparam int WW = CSP_W_WIDTH;

    // ------------------------------------------------------------------
    // Configuration register. The user must write it only while the pipeline is empty;
    // the block does not enforce this, and later stages read tension_reg directly.
    // ------------------------------------------------------------------
    logic [CSP_TENSION_WIDTH-1:0] tension_reg;
    logic                         cfg_index;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[CSP_PADDR_WIDTH-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= CSP_TENSION_RESET;
        end
        else if (cfg_write && (cfg_index == CSP_REG_TENSION))
        begin
            tension_reg <= pwdata[CSP_TENSION_WIDTH-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_index == CSP_REG_TENSION)
        begin
            prdata = CSP_PDATA_WIDTH'(tension_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage advances when it is empty or when the
    // stage after it advances; the last stage advances when the result is
    // taken. Bubbles therefore collapse, and new samples keep entering, until the
    // empty stages fill, while a finished result waits in the output register.
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || result_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? sample_valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_ready = adv[0];
    assign result_valid = valid_reg[NS-1];

    // ------------------------------------------------------------------
    // Delay lines for the opcode, the control values and the clamped u, which ride along
    // until stage 5, the weights (stage 7) and the products (stage 8) need them.
    // ------------------------------------------------------------------
    csp_op_t              op_pipe_reg [0:6];
    csp_coord_t           p_pipe_reg  [0:7][0:3];
    logic [UW-1:0]        uc_pipe_reg [0:4];
    logic [UW-1:0]        uc_next;

    // Stage 0: clamp u above one to exactly one
    assign uc_next = (sample.param_u > CSP_U_ONE) ? CSP_U_ONE : sample.param_u;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            op_pipe_reg[0]    <= sample.opcode;
            p_pipe_reg[0][0]  <= sample.ctrl_a;
            p_pipe_reg[0][1]  <= sample.ctrl_b;
            p_pipe_reg[0][2]  <= sample.ctrl_c;
            p_pipe_reg[0][3]  <= sample.ctrl_d;
            uc_pipe_reg[0]    <= uc_next;
        end
        for (int k = 1; k < 7; k++)
        begin
            if (adv[k])
            begin
                op_pipe_reg[k] <= op_pipe_reg[k-1];
            end
        end
        for (int k = 1; k < 8; k++)
        begin
            if (adv[k])
            begin
                p_pipe_reg[k] <= p_pipe_reg[k-1];
            end
        end
        for (int k = 1; k < 5; k++)
        begin
            if (adv[k])
            begin
                uc_pipe_reg[k] <= uc_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-4: u^2 and u^3, each product rounded half up back to Q1.F.
    // ------------------------------------------------------------------
    logic [CSP_UU_WIDTH-1:0] s1_uu_reg;
    logic [CSP_UU_WIDTH-1:0] uu_rnd;
    logic [UW-1:0]           s2_u2_reg;
    logic [UW-1:0]           s3_u2_reg;
    logic [CSP_UU_WIDTH-1:0] s3_u2u_reg;
    logic [CSP_UU_WIDTH-1:0] u2u_rnd;
    logic [UW-1:0]           s4_u2_reg;
    logic [UW-1:0]           s4_u3_reg;

    assign uu_rnd  = s1_uu_reg + CSP_U_HALF;
    assign u2u_rnd = s3_u2u_reg + CSP_U_HALF;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_uu_reg <= uc_pipe_reg[0] * uc_pipe_reg[0];
        end
        if (adv[2])
        begin
            s2_u2_reg <= uu_rnd[F +: UW];
        end
        if (adv[3])
        begin
            s3_u2_reg  <= s2_u2_reg;
            s3_u2u_reg <= s2_u2_reg * uc_pipe_reg[2];
        end
        if (adv[4])
        begin
            s4_u2_reg <= s3_u2_reg;
            s4_u3_reg <= u2u_rnd[F +: UW];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: tension-free parts of the basis weights. Catmull-Rom weights
    // are split as w0 = s*A, w1 = base1 - s*B, w2 = base2 - s*A, w3 = s*B
    // with A = -u3+2u2-u and B = u3-u2, so only two tension products remain.
    // Bezier weights are complete here, scaled by 256 to match.
    // ------------------------------------------------------------------
    logic signed [WW-1:0]              e_u;
    logic signed [WW-1:0]              e_u2;
    logic signed [WW-1:0]              e_u3;
    logic signed [WW-1:0]              e_one;
    logic signed [WW-1:0]              a_full;
    logic signed [WW-1:0]              b_full;
    logic signed [WW-1:0]              base1_next;
    logic signed [WW-1:0]              base2_next;
    logic signed [WW-1:0]              bz_next [0:3];
    logic signed [CSP_AB_WIDTH-1:0]    s5_a_reg;
    logic signed [CSP_AB_WIDTH-1:0]    s5_b_reg;
    logic signed [WW-1:0]              s5_base1_reg;
    logic signed [WW-1:0]              s5_base2_reg;
    logic signed [WW-1:0]              s5_bz_reg [0:3];

    always_comb
    begin
        e_u   = $signed(WW'(uc_pipe_reg[4]));
        e_u2  = $signed(WW'(s4_u2_reg));
        e_u3  = $signed(WW'(s4_u3_reg));
        e_one = $signed(WW'(CSP_U_ONE));

        a_full     = (e_u2 <<< 1) - e_u - e_u3;
        b_full     = e_u3 - e_u2;
        base1_next = (e_u3 <<< 9) - (e_u2 <<< 9) - (e_u2 <<< 8) + (e_one <<< 8);
        base2_next = (e_u2 <<< 9) + (e_u2 <<< 8) - (e_u3 <<< 9);

        bz_next[0] = ((e_u2 <<< 1) + e_u2 - (e_u <<< 1) - e_u - e_u3 + e_one) <<< 8;
        bz_next[1] = ((e_u3 <<< 1) + e_u3 - (e_u2 <<< 2) - (e_u2 <<< 1)
                      + (e_u <<< 1) + e_u) <<< 8;
        bz_next[2] = ((e_u2 <<< 1) + e_u2 - (e_u3 <<< 1) - e_u3) <<< 8;
        bz_next[3] = e_u3 <<< 8;
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_a_reg     <= a_full[CSP_AB_WIDTH-1:0];
            s5_b_reg     <= b_full[CSP_AB_WIDTH-1:0];
            s5_base1_reg <= base1_next;
            s5_base2_reg <= base2_next;
            s5_bz_reg    <= bz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: the two tension products s*A and s*B.
    // ------------------------------------------------------------------
    logic signed [CSP_TENSION_WIDTH:0] s_signed;
    logic signed [WW-1:0]              s6_sa_reg;
    logic signed [WW-1:0]              s6_sb_reg;
    logic signed [WW-1:0]              s6_base1_reg;
    logic signed [WW-1:0]              s6_base2_reg;
    logic signed [WW-1:0]              s6_bz_reg [0:3];

    assign s_signed = $signed({1'b0, tension_reg});

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_sa_reg    <= s_signed * s5_a_reg;
            s6_sb_reg    <= s_signed * s5_b_reg;
            s6_base1_reg <= s5_base1_reg;
            s6_base2_reg <= s5_base2_reg;
            s6_bz_reg    <= s5_bz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: pick the weights for the curve kind.
    // ------------------------------------------------------------------
    logic signed [WW-1:0] w_next [0:3];
    logic signed [WW-1:0] s7_w_reg [0:3];

    always_comb
    begin
        case (op_pipe_reg[6])
            CSP_OP_CATMULL_ROM:
            begin
                w_next[0] = s6_sa_reg;
                w_next[1] = s6_base1_reg - s6_sb_reg;
                w_next[2] = s6_base2_reg - s6_sa_reg;
                w_next[3] = s6_sb_reg;
            end
            default:
            begin
                w_next = s6_bz_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_w_reg <= w_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: weight times control value, as two half-width partial
    // products (unsigned low half, signed high half) per term.
    // Stage 9: recombine each term.
    // ------------------------------------------------------------------
    logic signed [CSP_LOP_WIDTH-1:0]  s8_lo_reg [0:3];
    logic signed [CSP_HIP_WIDTH-1:0]  s8_hi_reg [0:3];
    logic signed [CSP_PROD_WIDTH-1:0] s9_prod_reg [0:3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (adv[8])
            begin
                s8_lo_reg[i] <= $signed({1'b0, p_pipe_reg[7][i][CSP_LO_WIDTH-1:0]})
                                * s7_w_reg[i];
                s8_hi_reg[i] <= $signed(p_pipe_reg[7][i][CW-1:CSP_LO_WIDTH]) * s7_w_reg[i];
            end
            if (adv[9])
            begin
                s9_prod_reg[i] <= (CSP_PROD_WIDTH'(s8_hi_reg[i]) <<< CSP_LO_WIDTH)
                                  + CSP_PROD_WIDTH'(s8_lo_reg[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 10-11: sum the four terms plus the half-up rounding constant.
    // ------------------------------------------------------------------
    logic signed [CSP_ACC_WIDTH-1:0] s10_sum_reg [0:1];
    logic signed [CSP_ACC_WIDTH-1:0] s11_acc_reg;

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            s10_sum_reg[0] <= CSP_ACC_WIDTH'(s9_prod_reg[0]) + CSP_ACC_WIDTH'(s9_prod_reg[1]);
            s10_sum_reg[1] <= CSP_ACC_WIDTH'(s9_prod_reg[2]) + CSP_ACC_WIDTH'(s9_prod_reg[3])
                              + CSP_ROUND;
        end
        if (adv[11])
        begin
            s11_acc_reg <= s10_sum_reg[0] + s10_sum_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: drop the fraction bits (floor) and clip to the coordinate
    // range. The value fits when all bits above the coordinate's sign bit
    // agree with it; otherwise take the bound on the side of the sign.
    // ------------------------------------------------------------------
    logic [CSP_Q_WIDTH-1:0] q;
    logic                   q_fits;
    logic                   q_neg;
    csp_result_t            result_next;
    csp_result_t            result_reg;

    always_comb
    begin
        q      = s11_acc_reg[CSP_ACC_WIDTH-1:CSP_SHIFT];
        q_neg  = q[CSP_Q_WIDTH-1];
        q_fits = (&q[CSP_Q_WIDTH-1:CW-1]) || !(|q[CSP_Q_WIDTH-1:CW-1]);
        if (q_fits)
        begin
            result_next.curve_value = q[CW-1:0];
            result_next.saturated   = 1'b0;
        end
        else
        begin
            result_next.curve_value = q_neg ? {1'b1, {(CW-1){1'b0}}}
                                            : {1'b0, {(CW-1){1'b1}}};
            result_next.saturated   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[12])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
